// File: rtl/lfu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lfu_pkg;

    localparam int ENTRIES     = 8;
    localparam int KEY_WIDTH   = 32;
    localparam int COUNT_WIDTH = 16;

    // Field widths fixed by the register and command definitions.
    localparam int CAP_WIDTH = 4;
    localparam int CMD_WIDTH = 2;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CAP_WIDTH) ? OCC_W : CAP_WIDTH;

    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 4'd8;

    localparam logic [CMD_WIDTH-1:0] CMD_GET   = 2'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_PUT   = 2'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_DECAY = 2'd2;
    localparam logic [CMD_WIDTH-1:0] CMD_NONE  = 2'd3;

    typedef struct packed {
        logic [CMD_WIDTH-1:0] cmd;
        logic [KEY_WIDTH-1:0] key;
    } in_word_t;

    typedef struct packed {
        logic                   hit;
        logic [KEY_WIDTH-1:0]   value_out;
        logic                   evict_valid;
        logic [KEY_WIDTH-1:0]   evict_key;
        logic [COUNT_WIDTH-1:0] evict_count;
        logic                   new_dropped;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic scan;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/lfu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lfu_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  lfu_pkg::dp_stat_t   stat,
    output lfu_pkg::dp_cmd_t    cmd
);

    lfu_pkg::state_t state_reg;
    lfu_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lfu_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lfu_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = lfu_pkg::ST_SCAN;
                end
            end
            lfu_pkg::ST_SCAN: begin
                if (stat.scan_last) begin
                    state_next = lfu_pkg::ST_FINISH;
                end
            end
            lfu_pkg::ST_FINISH: begin
                if (stat.out_free) begin
                    state_next = lfu_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.scan    = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            lfu_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            lfu_pkg::ST_SCAN: begin
                cmd.scan = 1'b1;
            end
            lfu_pkg::ST_FINISH: begin
                cmd.commit = stat.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // The finish state is only reached through a full scan.
    a_finish_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lfu_pkg::ST_FINISH) |->
            ($past(state_reg) == lfu_pkg::ST_SCAN || $past(state_reg) == lfu_pkg::ST_FINISH))
        else $error("finish state entered without a scan");

    a_commit_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> (state_reg == lfu_pkg::ST_IDLE))
        else $error("controller did not return to idle after commit");

    a_scan_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lfu_pkg::ST_SCAN && stat.scan_last) |=> (state_reg == lfu_pkg::ST_FINISH))
        else $error("scan did not end on the last entry");

endmodule

`default_nettype wire

// File: rtl/lfu_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module lfu_dp (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  lfu_pkg::in_word_t                    s_data,
    input  wire                                  cfg_wr_en,
    input  wire  [lfu_pkg::CAP_WIDTH-1:0]        cfg_wr_data,
    input  lfu_pkg::dp_cmd_t                     cmd,
    output lfu_pkg::dp_stat_t                    stat,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output lfu_pkg::out_word_t                   m_data
);

    localparam int IW = lfu_pkg::IDX_W;
    localparam int KW = lfu_pkg::KEY_WIDTH;
    localparam int CW = lfu_pkg::COUNT_WIDTH;
    localparam int OW = lfu_pkg::OCC_W;
    localparam int MW = lfu_pkg::CMP_W;

    // Entry storage
    logic [lfu_pkg::ENTRIES-1:0] valid_reg;
    logic [KW-1:0]               key_mem [lfu_pkg::ENTRIES];
    logic [CW-1:0]               cnt_mem [lfu_pkg::ENTRIES];
    logic [lfu_pkg::CAP_WIDTH-1:0] cap_reg;

    // Operation and scan results
    logic [lfu_pkg::CMD_WIDTH-1:0] op_cmd_reg;
    logic [KW-1:0] op_key_reg;
    logic [IW-1:0] idx_reg;
    logic          found_reg;
    logic [IW-1:0] match_idx_reg;
    logic [CW-1:0] match_cnt_reg;
    logic          min_valid_reg;
    logic [IW-1:0] min_idx_reg;
    logic [CW-1:0] min_cnt_reg;
    logic [KW-1:0] min_key_reg;
    logic          free_found_reg;
    logic [IW-1:0] free_idx_reg;
    logic [OW-1:0] used_reg;

    logic               m_valid_reg;
    logic               m_valid_next;
    lfu_pkg::out_word_t out_reg;
    lfu_pkg::out_word_t out_next;

    logic [IW-1:0] rd_idx;
    logic [KW-1:0] rd_key_reg;
    logic [CW-1:0] rd_cnt_reg;

    logic          cur_valid;
    logic [KW-1:0] cur_key;
    logic [CW-1:0] cur_cnt;
    logic          cur_match;
    logic          cur_min;
    logic          cur_free;
    logic          decay_dec;

    logic          is_get;
    logic          is_put;
    logic [MW-1:0] cap_ext;
    logic [MW-1:0] eff_cap;
    logic          full;
    logic          evict;
    logic          dropped;
    logic          insert;
    logic [IW-1:0] wr_idx;
    logic          cnt_we;
    logic [CW-1:0] wr_cnt;
    logic [CW-1:0] bumped_cnt;

    // The entry for the next scan step is fetched into the read registers while the
    // current one is scanned, so during a scan the read data belongs to the entry at idx_reg.
    assign rd_idx = cmd.capture ? '0 : idx_reg + 1'b1;

    always_ff @(posedge aclk) begin
        rd_key_reg <= key_mem[rd_idx];
        rd_cnt_reg <= cnt_mem[rd_idx];
    end

    assign cur_valid = valid_reg[idx_reg];
    assign cur_key   = rd_key_reg;
    assign cur_cnt   = rd_cnt_reg;
    assign cur_match = cur_valid && (cur_key == op_key_reg);
    assign cur_min   = cur_valid && (!min_valid_reg || (cur_cnt < min_cnt_reg));
    assign cur_free  = !cur_valid && !free_found_reg;
    assign decay_dec = cmd.scan && (op_cmd_reg == lfu_pkg::CMD_DECAY) && cur_valid
                       && (cur_cnt != '0);

    assign stat.scan_last = (idx_reg == IW'(lfu_pkg::ENTRIES - 1));
    assign stat.out_free  = !m_valid_reg || m_ready;

    // Effective capacity is the register clamped to one through the entry count.
    assign cap_ext = MW'(cap_reg);
    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = MW'(1);
        end else if (cap_ext > MW'(lfu_pkg::ENTRIES)) begin
            eff_cap = MW'(lfu_pkg::ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
    end

    assign is_get     = (op_cmd_reg == lfu_pkg::CMD_GET);
    assign is_put     = (op_cmd_reg == lfu_pkg::CMD_PUT);
    assign full       = (MW'(used_reg) >= eff_cap);
    assign bumped_cnt = (match_cnt_reg == '1) ? match_cnt_reg : match_cnt_reg + 1'b1;

    always_comb begin
        evict   = 1'b0;
        dropped = 1'b0;
        insert  = 1'b0;
        wr_idx  = free_idx_reg;
        if (is_put && !found_reg) begin
            if (full) begin
                if (!min_valid_reg || (min_cnt_reg > CW'(1))) begin
                    dropped = 1'b1;
                end else begin
                    evict  = 1'b1;
                    insert = 1'b1;
                    wr_idx = min_idx_reg;
                end
            end else if (free_found_reg) begin
                insert = 1'b1;
            end else begin
                dropped = 1'b1;
            end
        end
        cnt_we = insert || ((is_get || is_put) && found_reg);
        if (insert) begin
            wr_cnt = CW'(1);
        end else begin
            wr_cnt = bumped_cnt;
            wr_idx = match_idx_reg;
        end
    end

    always_comb begin
        out_next             = '0;
        out_next.hit         = (is_get || is_put) && found_reg;
        out_next.value_out   = (is_get && found_reg) ? op_key_reg : '0;
        out_next.evict_valid = evict;
        out_next.evict_key   = evict ? min_key_reg : '0;
        out_next.evict_count = evict ? min_cnt_reg : '0;
        out_next.new_dropped = dropped;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            cap_reg     <= lfu_pkg::CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.commit && insert) begin
                valid_reg[wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (decay_dec) begin
            cnt_mem[idx_reg] <= cur_cnt - 1'b1;
        end
        if (cmd.commit && cnt_we) begin
            cnt_mem[wr_idx] <= wr_cnt;
        end
        if (cmd.commit && insert) begin
            key_mem[wr_idx] <= op_key_reg;
        end
        if (cmd.commit) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_cmd_reg     <= s_data.cmd;
            op_key_reg     <= s_data.key;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            min_valid_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            used_reg       <= '0;
        end else if (cmd.scan) begin
            idx_reg <= idx_reg + 1'b1;
            if (cur_match && !found_reg) begin
                found_reg     <= 1'b1;
                match_idx_reg <= idx_reg;
                match_cnt_reg <= cur_cnt;
            end
            if (cur_min) begin
                min_valid_reg <= 1'b1;
                min_idx_reg   <= idx_reg;
                min_cnt_reg   <= cur_cnt;
                min_key_reg   <= cur_key;
            end
            if (cur_free) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= idx_reg;
            end
            if (cur_valid) begin
                used_reg <= used_reg + 1'b1;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_commit_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> stat.out_free)
        else $error("result committed over a word still waiting");

    a_scan_starts_at_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (idx_reg == '0))
        else $error("scan index not cleared on capture");

    a_evict_excludes_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(out_reg.evict_valid && out_reg.new_dropped))
        else $error("result both evicts and drops");

    a_hit_excludes_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.hit) |-> (!out_reg.evict_valid && !out_reg.new_dropped))
        else $error("hit reported together with eviction or drop");

endmodule

`default_nettype wire

// File: rtl/lfu_cache_with_linear_decay.sv
// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    s_data  (cmd, key)
// m_       out        m_valid/m_ready    m_data  (hit, value_out, evict_*, new_dropped)
// cfg_     in         cfg_wr_en          cfg_wr_data (capacity)
//
// Each word is captured, then the store is scanned entry by entry through a
// single read port, and then the result is committed.
// One word is in work at a time; a finished result sits in the output register,
// and a new word is accepted while it waits to be taken.
// A stalled output only holds the commit cycle of the following word.
// Reset is synchronous: it clears the entry valid bits and sets capacity to 8.
`timescale 1ns / 1ps
`default_nettype none

module lfu_cache_with_linear_decay (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  lfu_pkg::in_word_t                s_data,
    output logic                             m_valid,
    input  wire                              m_ready,
    output lfu_pkg::out_word_t               m_data,
    input  wire                              cfg_wr_en,
    input  wire  [lfu_pkg::CAP_WIDTH-1:0]    cfg_wr_data
);

    lfu_pkg::dp_cmd_t  dp_cmd;
    lfu_pkg::dp_stat_t dp_stat;

    lfu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (dp_stat),
        .cmd     (dp_cmd)
    );

    lfu_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (dp_cmd),
        .stat        (dp_stat),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import lfu_pkg::*;

    localparam int CYCLE_LIMIT    = 4_000_000;
    localparam int SETTLE_CYCLES  = ENTRIES + 4;
    localparam int RAND_PHASES    = 7;
    localparam int RAND_PER_PHASE = 270;
    localparam int POOL_SIZE      = 8;
    localparam int HOT_GETS       = 40;
    localparam int MAX_PRINTS     = 40;

    localparam out_word_t NO_RESULT = '0;
    localparam out_word_t GET_HIT_ONES =
        {1'b1, {KEY_WIDTH{1'b1}}, 1'b0, {KEY_WIDTH{1'b0}}, {COUNT_WIDTH{1'b0}}, 1'b0};
    localparam out_word_t PUT_HIT =
        {1'b1, {KEY_WIDTH{1'b0}}, 1'b0, {KEY_WIDTH{1'b0}}, {COUNT_WIDTH{1'b0}}, 1'b0};

    typedef enum logic {
        ROW_WORD,
        ROW_CAP
    } row_kind_t;

    // For ROW_CAP rows the capacity value travels in the low bits of key.
    typedef struct {
        row_kind_t            kind;
        logic [CMD_WIDTH-1:0] cmd;
        logic [KEY_WIDTH-1:0] key;
        int                   reps;
        bit                   typed;
        out_word_t            want;
    } script_row_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    in_word_t             s_data      = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    out_word_t            m_data;
    logic                 cfg_wr_en   = 1'b0;
    logic [CAP_WIDTH-1:0] cfg_wr_data = '0;

    // Mirror of the store used to predict each result.
    bit                     slot_used [ENTRIES] = '{default: 1'b0};
    logic [KEY_WIDTH-1:0]   slot_key  [ENTRIES];
    logic [COUNT_WIDTH-1:0] slot_hits [ENTRIES];
    logic [CAP_WIDTH-1:0]   cap_reg = CAP_RESET;

    out_word_t pending_results [$];
    out_word_t want_w;

    int  cycle_cnt     = 0;
    int  mismatch_cnt  = 0;
    int  words_sent    = 0;
    int  results_seen  = 0;
    int  evict_cnt     = 0;
    int  drop_cnt      = 0;
    int  hit_cnt       = 0;
    int  burst_left    = 0;
    bit  sender_idle_on = 1'b1;
    bit  rx_stall_on    = 1'b1;
    bit  rx_open        = 1'b0;
    int  rx_run         = 0;

    script_row_t script [28] = '{
        '{ROW_WORD, CMD_GET,   32'h0000_0000, 1,         1'b1, NO_RESULT},
        '{ROW_CAP,  CMD_NONE,  32'd1,         1,         1'b0, NO_RESULT},
        '{ROW_WORD, CMD_PUT,   32'hC3C3_C3C3, 1,         1'b1, NO_RESULT},
        '{ROW_WORD, CMD_GET,   32'hC3C3_C3C3, HOT_GETS,  1'b0, NO_RESULT},
        '{ROW_WORD, CMD_PUT,   32'hFFFF_FFFF, 1,         1'b0, NO_RESULT},
        '{ROW_WORD, CMD_GET,   32'hFFFF_FFFF, 1,         1'b1, NO_RESULT},
        '{ROW_WORD, CMD_DECAY, 32'h0000_0000, 1,         1'b1, NO_RESULT},
        '{ROW_WORD, CMD_NONE,  32'h1234_5678, 1,         1'b1, NO_RESULT},
        '{ROW_CAP,  CMD_NONE,  32'd8,         1,         1'b0, NO_RESULT},
        '{ROW_WORD, CMD_PUT,   32'hFFFF_FFFF, 1,         1'b0, NO_RESULT},
        '{ROW_WORD, CMD_GET,   32'hFFFF_FFFF, 1,         1'b1, GET_HIT_ONES},
        '{ROW_WORD, CMD_PUT,   32'hFFFF_FFFF, 1,         1'b1, PUT_HIT},
        '{ROW_WORD, CMD_PUT,   32'h0000_0000, 1,         1'b0, NO_RESULT},
        '{ROW_CAP,  CMD_NONE,  32'd3,         1,         1'b0, NO_RESULT},
        '{ROW_WORD, CMD_PUT,   32'hA5A5_A5A5, 1,         1'b0, NO_RESULT},
        '{ROW_WORD, CMD_GET,   32'hA5A5_A5A5, 1,         1'b0, NO_RESULT},
        '{ROW_WORD, CMD_PUT,   32'h5A5A_5A5A, 1,         1'b0, NO_RESULT},
        '{ROW_WORD, CMD_DECAY, 32'h0000_0000, 1,         1'b1, NO_RESULT},
        '{ROW_WORD, CMD_DECAY, 32'hFFFF_FFFF, 1,         1'b1, NO_RESULT},
        '{ROW_WORD, CMD_DECAY, 32'h0000_0000, 1,         1'b1, NO_RESULT},
        '{ROW_WORD, CMD_PUT,   32'h0000_0001, 1,         1'b0, NO_RESULT},
        '{ROW_CAP,  CMD_NONE,  32'd0,         1,         1'b0, NO_RESULT},
        '{ROW_WORD, CMD_PUT,   32'h0000_0002, 1,         1'b0, NO_RESULT},
        '{ROW_WORD, CMD_PUT,   32'h0000_0003, 1,         1'b0, NO_RESULT},
        '{ROW_CAP,  CMD_NONE,  32'd15,        1,         1'b0, NO_RESULT},
        '{ROW_WORD, CMD_PUT,   32'h8000_0000, 1,         1'b0, NO_RESULT},
        '{ROW_WORD, CMD_GET,   32'h7FFF_FFFF, 1,         1'b1, NO_RESULT},
        '{ROW_WORD, CMD_GET,   32'h0000_0001, 1,         1'b1, NO_RESULT}
    };

    lfu_cache_with_linear_decay i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Applies one word to the mirrored store and returns the result it must produce.
    function automatic out_word_t lfu_apply(input in_word_t w);
        out_word_t r;
        int        i;
        int        found;
        int        victim;
        int        occupied;
        int        lim;
        r        = '0;
        found    = -1;
        victim   = -1;
        occupied = 0;
        for (i = 0; i < ENTRIES; i++) begin
            if (slot_used[i] && slot_key[i] == w.key && found < 0)
                found = i;
        end
        case (w.cmd)
            CMD_GET: begin
                if (found >= 0) begin
                    if (slot_hits[found] != '1)
                        slot_hits[found]++;
                    r.hit       = 1'b1;
                    r.value_out = w.key;
                end
            end
            CMD_PUT: begin
                if (found >= 0) begin
                    if (slot_hits[found] != '1)
                        slot_hits[found]++;
                    r.hit = 1'b1;
                end else begin
                    for (i = 0; i < ENTRIES; i++)
                        if (slot_used[i])
                            occupied++;
                    if (cap_reg == 0)
                        lim = 1;
                    else if (cap_reg > ENTRIES)
                        lim = ENTRIES;
                    else
                        lim = int'(cap_reg);
                    if (occupied >= lim) begin
                        // Lowest count wins; strict compare keeps the lowest slot on a tie.
                        for (i = 0; i < ENTRIES; i++) begin
                            if (slot_used[i] && (victim < 0 || slot_hits[i] < slot_hits[victim]))
                                victim = i;
                        end
                        if (slot_hits[victim] > 1) begin
                            r.new_dropped = 1'b1;
                        end else begin
                            r.evict_valid = 1'b1;
                            r.evict_key   = slot_key[victim];
                            r.evict_count = slot_hits[victim];
                        end
                    end else begin
                        for (i = ENTRIES - 1; i >= 0; i--)
                            if (!slot_used[i])
                                victim = i;
                    end
                    if (!r.new_dropped) begin
                        slot_used[victim] = 1'b1;
                        slot_key[victim]  = w.key;
                        slot_hits[victim] = COUNT_WIDTH'(1);
                    end
                end
            end
            CMD_DECAY: begin
                for (i = 0; i < ENTRIES; i++)
                    if (slot_used[i] && slot_hits[i] != 0)
                        slot_hits[i]--;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_PRINTS)
            $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    endtask

    task automatic send_word(input logic [CMD_WIDTH-1:0] cmd, input logic [KEY_WIDTH-1:0] key,
                             input bit typed, input out_word_t want);
        in_word_t  w;
        out_word_t pred;
        int        gap;
        w.cmd = cmd;
        w.key = key;
        if (sender_idle_on) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 12);
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        pred = lfu_apply(w);
        words_sent++;
        evict_cnt += pred.evict_valid;
        drop_cnt  += pred.new_dropped;
        hit_cnt   += pred.hit;
        pending_results.push_back(typed ? want : pred);
    endtask

    // Holds the input off until every outstanding word has come back.
    task automatic drain_pipeline();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_WIDTH-1:0] v);
        drain_pipeline();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        cap_reg = v;
    endtask

    // Receiver alternates ready runs and stall runs of random length.
    always @(negedge aclk) begin
        if (!rx_stall_on) begin
            m_ready <= 1'b1;
            rx_run = 0;
        end else if (rx_run == 0) begin
            rx_open = !rx_open;
            rx_run  = rx_open ? $urandom_range(1, 10) : $urandom_range(1, 6);
            m_ready <= rx_open;
        end else begin
            rx_run--;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("word with nothing expected", '0, m_data.value_out);
            end else begin
                want_w = pending_results.pop_front();
                results_seen++;
                if (m_data.hit !== want_w.hit)
                    report_mismatch("hit", want_w.hit, m_data.hit);
                if (m_data.value_out !== want_w.value_out)
                    report_mismatch("value_out", want_w.value_out, m_data.value_out);
                if (m_data.evict_valid !== want_w.evict_valid)
                    report_mismatch("evict_valid", want_w.evict_valid, m_data.evict_valid);
                if (m_data.evict_key !== want_w.evict_key)
                    report_mismatch("evict_key", want_w.evict_key, m_data.evict_key);
                if (m_data.evict_count !== want_w.evict_count)
                    report_mismatch("evict_count", want_w.evict_count, m_data.evict_count);
                if (m_data.new_dropped !== want_w.new_dropped)
                    report_mismatch("new_dropped", want_w.new_dropped, m_data.new_dropped);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words still outstanding",
                     cycle_cnt, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        logic [KEY_WIDTH-1:0] key_pool [POOL_SIZE];
        logic [CMD_WIDTH-1:0] cmd;
        logic [KEY_WIDTH-1:0] key;
        logic [CAP_WIDTH-1:0] phase_caps [RAND_PHASES];
        int                   phase;
        int                   n;
        int                   i;
        int                   pick;
        phase_caps = '{4'd8, 4'd1, 4'd4, 4'd15, 4'd0, 4'd2, 4'd8};
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (script[r]) begin
            if (script[r].kind == ROW_CAP) begin
                write_capacity(script[r].key[CAP_WIDTH-1:0]);
            end else begin
                // The long run of repeated gets goes at full rate on both sides.
                if (script[r].reps > 1) begin
                    sender_idle_on = 1'b0;
                    rx_stall_on    = 1'b0;
                end
                repeat (script[r].reps)
                    send_word(script[r].cmd, script[r].key, script[r].typed, script[r].want);
                sender_idle_on = 1'b1;
                rx_stall_on    = 1'b1;
            end
        end

        for (phase = 0; phase < RAND_PHASES; phase++) begin
            if (phase == RAND_PHASES - 1)
                phase_caps[phase] = CAP_WIDTH'($urandom_range(1, 15));
            write_capacity(phase_caps[phase]);
            sender_idle_on = (phase != 3);
            rx_stall_on    = (phase != 3);
            for (i = 0; i < POOL_SIZE; i++)
                key_pool[i] = $urandom;
            for (n = 0; n < RAND_PER_PHASE; n++) begin
                if (n == RAND_PER_PHASE / 2)
                    drain_pipeline();
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    cmd = CMD_GET;
                else if (pick < 80)
                    cmd = CMD_PUT;
                else if (pick < 93)
                    cmd = CMD_DECAY;
                else
                    cmd = CMD_NONE;
                // Mostly a small pool of keys so that hits, evictions and drops occur.
                if ($urandom_range(0, 9) == 0)
                    key = $urandom;
                else
                    key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                send_word(cmd, key, 1'b0, NO_RESULT);
            end
        end

        drain_pipeline();
        $display("Checked %0d words over %0d capacity settings in %0d cycles.",
                 results_seen, RAND_PHASES + 5, cycle_cnt);
        $display("Saw %0d hits, %0d evictions and %0d dropped puts; %0d mismatches.",
                 hit_cnt, evict_cnt, drop_cnt, mismatch_cnt);
        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
